// ===== src/assert_macros.svh =====
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/avrsf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package avrsf_pkg;

  typedef enum logic [4:0] {
    OP_ADD     = 5'd0,
    OP_ADC     = 5'd1,
    OP_ADIW    = 5'd2,
    OP_AND     = 5'd3,
    OP_OR      = 5'd4,
    OP_EOR     = 5'd5,
    OP_COM     = 5'd6,
    OP_NEG     = 5'd7,
    OP_INC     = 5'd8,
    OP_DEC     = 5'd9,
    OP_ASR     = 5'd10,
    OP_LSR     = 5'd11,
    OP_SWAP    = 5'd12,
    OP_CP      = 5'd13,
    OP_CPC     = 5'd14,
    OP_MUL     = 5'd15,
    OP_MULS    = 5'd16,
    OP_MUL_SU  = 5'd17,
    OP_FMUL    = 5'd18,
    OP_FMUL_SS = 5'd19,
    OP_FMUL_SU = 5'd20,
    OP_BSET    = 5'd21,
    OP_BCLR    = 5'd22,
    OP_BST     = 5'd23,
    OP_BLD     = 5'd24,
    OP_BRBS    = 5'd25,
    OP_BRBC    = 5'd26,
    OP_MOV     = 5'd27
  } op_t;

  localparam logic [1:0] WK_NONE   = 2'd0;
  localparam logic [1:0] WK_BYTE   = 2'd1;
  localparam logic [1:0] WK_WORD   = 2'd2;
  localparam logic [1:0] WK_PAIR01 = 2'd3;

  localparam int FL_C = 0;
  localparam int FL_Z = 1;
  localparam int FL_N = 2;
  localparam int FL_V = 3;
  localparam int FL_S = 4;
  localparam int FL_H = 5;
  localparam int FL_T = 6;

  localparam logic [7:0] BYTE_MIN_NEG = 8'h80;
  localparam logic [7:0] BYTE_MAX_POS = 8'h7f;
  localparam logic [7:0] BYTE_ONES    = 8'hff;

  typedef struct packed {
    logic [4:0]  operation;
    logic [7:0]  dest_value;
    logic [7:0]  source_value;
    logic [15:0] pair_value;
    logic [5:0]  word_immediate;
    logic [2:0]  bit_select;
    logic [7:0]  flags_in;
  } in_beat_t;

  typedef struct packed {
    logic [4:0]  op;
    logic [7:0]  d;
    logic [7:0]  r;
    logic [2:0]  bs;
    logic [7:0]  flags;
    logic [7:0]  res8;
    logic [15:0] word;
    logic        pair_msb;
    logic [15:0] prod;
  } mid_beat_t;

  typedef struct packed {
    logic [7:0] result_low;
    logic [7:0] result_high;
    logic [1:0] write_kind;
    logic [7:0] flags_out;
    logic       branch_taken;
  } out_beat_t;

endpackage

`default_nettype wire

// ===== src/avrsf_exec.sv =====
`timescale 1ns / 1ps
`default_nettype none

module avrsf_exec import avrsf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      up_valid,
  output logic           up_ready,
  input  wire in_beat_t  up_data,
  output logic           dn_valid,
  input  wire logic      dn_ready,
  output mid_beat_t      dn_data
);

  logic              valid_r;
  mid_beat_t         data_r;
  mid_beat_t         data_nxt;
  logic              cin;
  logic              sign_a;
  logic              sign_b;
  logic signed [8:0] mul_a;
  logic signed [8:0] mul_b;
  logic signed [17:0] prod_full;
  logic [7:0]        d;
  logic [7:0]        r;
  logic [7:0]        bld_res;

  assign d = up_data.dest_value;
  assign r = up_data.source_value;

  always_comb begin
    cin = ((up_data.operation == OP_ADC) || (up_data.operation == OP_CPC))
          ? up_data.flags_in[FL_C] : 1'b0;
    sign_a = (up_data.operation == OP_MULS) || (up_data.operation == OP_FMUL_SS) ||
             (up_data.operation == OP_MUL_SU) || (up_data.operation == OP_FMUL_SU);
    sign_b = (up_data.operation == OP_MULS) || (up_data.operation == OP_FMUL_SS);
    mul_a = $signed({sign_a & d[7], d});
    mul_b = $signed({sign_b & r[7], r});
    prod_full = mul_a * mul_b;
    bld_res = d;
    bld_res[up_data.bit_select] = up_data.flags_in[FL_T];
  end

  always_comb begin
    data_nxt.op       = up_data.operation;
    data_nxt.d        = d;
    data_nxt.r        = r;
    data_nxt.bs       = up_data.bit_select;
    data_nxt.flags    = up_data.flags_in;
    data_nxt.word     = up_data.pair_value + {10'd0, up_data.word_immediate};
    data_nxt.pair_msb = up_data.pair_value[15];
    data_nxt.prod     = prod_full[15:0];
    unique case (up_data.operation) inside
      OP_ADD, OP_ADC: data_nxt.res8 = d + r + {7'd0, cin};
      OP_AND:         data_nxt.res8 = d & r;
      OP_OR:          data_nxt.res8 = d | r;
      OP_EOR:         data_nxt.res8 = d ^ r;
      OP_COM:         data_nxt.res8 = ~d;
      OP_NEG:         data_nxt.res8 = 8'd0 - d;
      OP_INC:         data_nxt.res8 = d + 8'd1;
      OP_DEC:         data_nxt.res8 = d + BYTE_ONES;
      OP_ASR:         data_nxt.res8 = {d[7], d[7:1]};
      OP_LSR:         data_nxt.res8 = {1'b0, d[7:1]};
      OP_SWAP:        data_nxt.res8 = {d[3:0], d[7:4]};
      OP_CP, OP_CPC:  data_nxt.res8 = d - r - {7'd0, cin};
      OP_BLD:         data_nxt.res8 = bld_res;
      OP_MOV:         data_nxt.res8 = r;
      default:        data_nxt.res8 = 8'd0;
    endcase
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// ===== src/avrsf_flags.sv =====
`timescale 1ns / 1ps
`default_nettype none

module avrsf_flags import avrsf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      up_valid,
  output logic           up_ready,
  input  wire mid_beat_t up_data,
  output logic           dn_valid,
  input  wire logic      dn_ready,
  output out_beat_t      dn_data
);

  logic       valid_r;
  out_beat_t  data_r;
  out_beat_t  data_nxt;
  logic [7:0] f;
  logic [7:0] d;
  logic [7:0] r;
  logic [7:0] s;
  logic [15:0] w;
  logic [15:0] pp;
  logic       frac;

  assign d = up_data.d;
  assign r = up_data.r;
  assign s = up_data.res8;
  assign w = up_data.word;
  assign frac = (up_data.op == OP_FMUL) || (up_data.op == OP_FMUL_SS) ||
                (up_data.op == OP_FMUL_SU);
  assign pp = frac ? {up_data.prod[14:0], 1'b0} : up_data.prod;

  always_comb begin
    f = up_data.flags;
    data_nxt.result_low   = 8'd0;
    data_nxt.result_high  = 8'd0;
    data_nxt.write_kind   = WK_NONE;
    data_nxt.branch_taken = 1'b0;
    unique case (up_data.op) inside
      OP_ADD, OP_ADC: begin
        f[FL_H] = (d[3] & r[3]) | (r[3] & ~s[3]) | (~s[3] & d[3]);
        f[FL_V] = (d[7] & r[7] & ~s[7]) | (~d[7] & ~r[7] & s[7]);
        f[FL_C] = (d[7] & r[7]) | (r[7] & ~s[7]) | (~s[7] & d[7]);
        f[FL_N] = s[7];
        f[FL_Z] = (s == 8'd0);
        f[FL_S] = s[7] ^ f[FL_V];
        data_nxt.result_low = s;
        data_nxt.write_kind = WK_BYTE;
      end
      OP_ADIW: begin
        f[FL_V] = ~up_data.pair_msb & w[15];
        f[FL_C] = ~w[15] & up_data.pair_msb;
        f[FL_N] = w[15];
        f[FL_Z] = (w == 16'd0);
        f[FL_S] = w[15] ^ f[FL_V];
        data_nxt.result_low  = w[7:0];
        data_nxt.result_high = w[15:8];
        data_nxt.write_kind  = WK_WORD;
      end
      OP_AND, OP_OR, OP_EOR, OP_COM: begin
        if (up_data.op == OP_COM) begin
          f[FL_C] = 1'b1;
        end
        f[FL_V] = 1'b0;
        f[FL_N] = s[7];
        f[FL_Z] = (s == 8'd0);
        f[FL_S] = s[7];
        data_nxt.result_low = s;
        data_nxt.write_kind = WK_BYTE;
      end
      OP_NEG: begin
        f[FL_H] = s[3] | d[3];
        f[FL_V] = (s == BYTE_MIN_NEG);
        f[FL_C] = (s != 8'd0);
        f[FL_N] = s[7];
        f[FL_Z] = (s == 8'd0);
        f[FL_S] = s[7] ^ f[FL_V];
        data_nxt.result_low = s;
        data_nxt.write_kind = WK_BYTE;
      end
      OP_INC, OP_DEC: begin
        f[FL_V] = (up_data.op == OP_INC) ? (d == BYTE_MAX_POS) : (d == BYTE_MIN_NEG);
        f[FL_N] = s[7];
        f[FL_Z] = (s == 8'd0);
        f[FL_S] = s[7] ^ f[FL_V];
        data_nxt.result_low = s;
        data_nxt.write_kind = WK_BYTE;
      end
      OP_ASR, OP_LSR: begin
        f[FL_C] = d[0];
        f[FL_N] = s[7];
        f[FL_V] = s[7] ^ d[0];
        f[FL_Z] = (s == 8'd0);
        f[FL_S] = s[7] ^ f[FL_V];
        data_nxt.result_low = s;
        data_nxt.write_kind = WK_BYTE;
      end
      OP_CP, OP_CPC: begin
        f[FL_H] = (~d[3] & r[3]) | (r[3] & s[3]) | (s[3] & ~d[3]);
        f[FL_V] = (d[7] & ~r[7] & ~s[7]) | (~d[7] & r[7] & s[7]);
        f[FL_C] = (~d[7] & r[7]) | (r[7] & s[7]) | (s[7] & ~d[7]);
        f[FL_N] = s[7];
        f[FL_S] = s[7] ^ f[FL_V];
        f[FL_Z] = (up_data.op == OP_CP) ? (s == 8'd0)
                                         : ((s == 8'd0) & up_data.flags[FL_Z]);
        data_nxt.result_low = s;
      end
      OP_MUL, OP_MULS, OP_MUL_SU, OP_FMUL, OP_FMUL_SS, OP_FMUL_SU: begin
        f[FL_C] = up_data.prod[15];
        f[FL_Z] = (pp == 16'd0);
        data_nxt.result_low  = pp[7:0];
        data_nxt.result_high = pp[15:8];
        data_nxt.write_kind  = WK_PAIR01;
      end
      OP_BSET: f = f | (8'd1 << up_data.bs);
      OP_BCLR: f = f & ~(8'd1 << up_data.bs);
      OP_BST:  f[FL_T] = d[up_data.bs];
      OP_BRBS: data_nxt.branch_taken = up_data.flags[up_data.bs];
      OP_BRBC: data_nxt.branch_taken = ~up_data.flags[up_data.bs];
      OP_SWAP, OP_BLD, OP_MOV: begin
        data_nxt.result_low = s;
        data_nxt.write_kind = WK_BYTE;
      end
      default: data_nxt.result_low = 8'd0;
    endcase
    data_nxt.flags_out = f;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// ===== src/avr_alu_with_status_flags_top.sv =====
// Stages: input, execute and flag registers lie between input beat and output beat.
// Throughput: one beat per cycle; each register stage holds when its successor is full.
// Each stage accepts a beat whenever it is empty or its contents move on the same edge.
// Reset: synchronous, active low; clears all stage valid bits, no data is held over.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module avr_alu_with_status_flags_top import avrsf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_beat_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_beat_t     out_data
);

  logic      s0_valid_r;
  in_beat_t  s0_data_r;
  logic      exec_ready;
  logic      mid_valid;
  logic      mid_ready;
  mid_beat_t mid_data;

  assign in_ready = !s0_valid_r || exec_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s0_data_r <= in_data;
    end
  end

  avrsf_exec u_exec (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s0_valid_r),
    .up_ready (exec_ready),
    .up_data  (s0_data_r),
    .dn_valid (mid_valid),
    .dn_ready (mid_ready),
    .dn_data  (mid_data)
  );

  avrsf_flags u_flags (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mid_valid),
    .up_ready (mid_ready),
    .up_data  (mid_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (out_data)
  );

  `ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid, "output valid after reset")
  `ASSERT_CLK(a_drain_opens_input, out_ready |-> in_ready, "input stalled with open output")
  `ASSERT_CLK(a_branch_no_write, (out_valid && out_data.branch_taken) |-> (out_data.write_kind == WK_NONE), "branch beat carries a write")

endmodule

`default_nettype wire
